[rtl/mecn_pkg.sv]
// shared types and constants for the min-eigenvalue corner detector with nms
package mecn_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_DATA_W = 33;
  localparam int CFG_ADDR_W = 2;

  localparam int SCORE_W    = 34;
  localparam int ROOT_W     = 34;
  localparam int ROOT_STEPS = 34;
  localparam int STEP_CNT_W = 6;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MARGIN       = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_D,
    ST_SQ_C,
    ST_SUM,
    ST_ROOT,
    ST_SCORE,
    ST_FIN
  } mecn_state_t;

  typedef struct packed {
    logic load;
    logic mul_d;
    logic mul_c;
    logic sum;
    logic root_step;
    logic score;
    logic fin;
  } mecn_cmd_t;

  typedef struct packed {
    logic out_free;
  } mecn_status_t;

endpackage

[rtl/mecn_ram.sv]
// generic single-port ram with registered read
module mecn_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/mecn_ctrl.sv]
// controller state machine sequencing one pixel through the datapath
module mecn_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  mecn_pkg::mecn_status_t status,
  output mecn_pkg::mecn_cmd_t   cmd
);
  import mecn_pkg::*;

  mecn_state_t state_r, state_nxt;
  logic [STEP_CNT_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SQ_D;
      ST_SQ_D:  state_nxt = ST_SQ_C;
      ST_SQ_C:  state_nxt = ST_SUM;
      ST_SUM: begin
        state_nxt = ST_ROOT;
        step_nxt  = '0;
      end
      ST_ROOT: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_CNT_W'(ROOT_STEPS - 1)) state_nxt = ST_SCORE;
      end
      ST_SCORE: state_nxt = ST_FIN;
      ST_FIN:   if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SQ_D:  cmd.mul_d     = 1'b1;
      ST_SQ_C:  cmd.mul_c     = 1'b1;
      ST_SUM:   cmd.sum       = 1'b1;
      ST_ROOT:  cmd.root_step = 1'b1;
      ST_SCORE: cmd.score     = 1'b1;
      ST_FIN:   cmd.fin       = status.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/mecn_dp.sv]
// datapath: score arithmetic, line buffer, 3x3 window and output register
module mecn_dp #(
  parameter int MAX_WIDTH  = mecn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mecn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mecn_pkg::mecn_cmd_t                 cmd,
  output mecn_pkg::mecn_status_t              status,
  input  logic [mecn_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                cfg_we,
  input  logic [mecn_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mecn_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mecn_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import mecn_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int EW0 = (CW > RW) ? CW + 1 : RW + 1;
  localparam int EW  = ((EW0 > 12) ? EW0 : 12) + 1;
  localparam int LW  = 2 * SCORE_W;

  // configuration
  logic [11:0]            img_w_r, img_h_r;
  logic signed [32:0]     thr_r;
  logic [9:0]             margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= 12'd640;
      img_h_r  <= 12'd480;
      thr_r    <= '0;
      margin_r <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  img_w_r  <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: img_h_r  <= cfg_data[11:0];
        REG_THRESHOLD:    thr_r    <= cfg_data;
        REG_MARGIN:       margin_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] eff_w, eff_h, eff_m;
  always_comb begin
    eff_w = EW'(img_w_r);
    if (eff_w < EW'(3)) eff_w = EW'(3);
    else if (eff_w > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
    eff_h = EW'(img_h_r);
    if (eff_h < EW'(3)) eff_h = EW'(3);
    else if (eff_h > EW'(MAX_HEIGHT)) eff_h = EW'(MAX_HEIGHT);
    eff_m = (margin_r == '0) ? EW'(1) : EW'(margin_r);
  end

  // position of the next pixel
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] cur_c_r;
  logic [RW-1:0] cur_r_r;
  logic [EW-1:0] acc_c, acc_r;

  // wrap again in case the size was shrunk by a register write
  always_comb begin
    if (EW'(col_r) >= eff_w) begin
      acc_c = '0;
      acc_r = EW'(row_r) + EW'(1);
    end else begin
      acc_c = EW'(col_r);
      acc_r = EW'(row_r);
    end
    if (acc_r >= eff_h) acc_r = '0;
  end

  // pixel payload
  logic [31:0] gxx_r, gyy_r, d_r, c_r;
  logic [63:0] d2_r, c2_r;
  logic [67:0] rad_r;
  logic [35:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic signed [SCORE_W-1:0] cur_s_r;

  logic [31:0] gxy_in;
  assign gxy_in = in_tdata[63:32];

  logic [31:0] mul_a;
  logic [63:0] mul_p;
  assign mul_a = cmd.mul_d ? d_r : c_r;
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_a};

  // one root bit per step: restoring digit recurrence
  logic [37:0] rem_sh, trial;
  logic        take;
  assign rem_sh = {rem_r, rad_r[67:66]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign take   = rem_sh >= trial;

  logic [34:0] sc_diff;
  assign sc_diff = {2'b00, ({1'b0, gxx_r} + {1'b0, gyy_r})} - {1'b0, root_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gxx_r   <= in_tdata[31:0];
      gyy_r   <= in_tdata[95:64];
      d_r     <= (in_tdata[31:0] >= in_tdata[95:64]) ? in_tdata[31:0] - in_tdata[95:64]
                                                      : in_tdata[95:64] - in_tdata[31:0];
      c_r     <= gxy_in[31] ? (~gxy_in + 32'd1) : gxy_in;
      cur_c_r <= acc_c[CW-1:0];
      cur_r_r <= acc_r[RW-1:0];
    end
    if (cmd.mul_d) d2_r <= mul_p;
    if (cmd.mul_c) c2_r <= mul_p;
    if (cmd.sum) begin
      rad_r  <= {4'd0, d2_r} + {2'b00, c2_r, 2'b00};
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.root_step) begin
      rad_r  <= {rad_r[65:0], 2'b00};
      rem_r  <= take ? 36'(rem_sh - trial) : rem_sh[35:0];
      root_r <= {root_r[ROOT_W-2:0], take};
    end
    if (cmd.score) cur_s_r <= sc_diff[34:1];
  end

  // line buffer: low half row r-2, high half row r-1
  logic [LW-1:0] line_q;
  mecn_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (cmd.fin),
    .re    (cmd.load),
    .addr  (cmd.load ? acc_c[CW-1:0] : cur_c_r),
    .wdata ({cur_s_r, line_q[LW-1:SCORE_W]}),
    .rdata (line_q)
  );

  logic signed [SCORE_W-1:0] top_s, mid_s;
  assign top_s = line_q[SCORE_W-1:0];
  assign mid_s = line_q[LW-1:SCORE_W];

  // window: index 0..2 column c-1 rows r-2..r, 3..5 column c-2
  logic signed [SCORE_W-1:0] win_r [6];

  logic [EW-1:0] r_ext, c_ext, cr, cc;
  logic in_region, is_max, found;
  logic signed [SCORE_W-1:0] s_ctr;
  assign r_ext = EW'(cur_r_r);
  assign c_ext = EW'(cur_c_r);
  assign cr    = r_ext - EW'(1);
  assign cc    = c_ext - EW'(1);
  assign s_ctr = win_r[1];
  assign in_region = (r_ext >= eff_m + EW'(1)) && (r_ext + eff_m <= eff_h) &&
                     (c_ext >= eff_m + EW'(1)) && (c_ext + eff_m <= eff_w);
  assign is_max = (s_ctr >= SCORE_W'(thr_r)) &&
                  (s_ctr >= win_r[0]) && (s_ctr >= win_r[2]) &&
                  (s_ctr >= win_r[3]) && (s_ctr >= win_r[4]) &&
                  (s_ctr >= win_r[5]) &&
                  (s_ctr >= top_s) && (s_ctr >= mid_s) && (s_ctr >= cur_s_r);
  assign found = in_region && is_max;

  always_comb begin
    col_nxt = cur_c_r + CW'(1);
    row_nxt = cur_r_r;
    if (c_ext + EW'(1) >= eff_w) begin
      col_nxt = '0;
      row_nxt = (r_ext + EW'(1) >= eff_h) ? '0 : RW'(r_ext + EW'(1));
    end
  end

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.fin && found) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.fin) begin
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        win_r[3] <= win_r[0];
        win_r[4] <= win_r[1];
        win_r[5] <= win_r[2];
        win_r[0] <= top_s;
        win_r[1] <= mid_s;
        win_r[2] <= cur_s_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && found) begin
      out_data_r <= {1'b0, s_ctr[32:0], cc[10:0], cr[10:0]};
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;

endmodule

[rtl/min_eigen_corner_nms_unit.sv]
// top level of the min-eigenvalue corner detector with 3x3 non-maximum suppression
// Pixels of structure-tensor sums arrive in raster order, one per transaction; each
// is scored as the minimum eigenvalue and checked against its eight neighbours and
// the threshold. One pixel is in work at a time; after acceptance it passes through
// the shared 32x32 squarer (d, then c), the radicand sum, the one-bit-a-step square
// root and the score, and retires in the neighbourhood check and line-buffer write.
// A feature is reported when its lower-right neighbour retires; a waiting result
// holds only the final step of the next pixel. The line buffer needs no clearing
// after reset.
module min_eigen_corner_nms_unit #(
  parameter int MAX_WIDTH  = mecn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mecn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sum_xx[31:0], sum_xy[63:32], sum_yy[95:64]
  input  logic [mecn_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // feature_row[10:0], feature_col[21:11], feature_score[54:22], zero[55]
  output logic [mecn_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [mecn_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mecn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mecn_pkg::*;

  mecn_cmd_t    cmd;
  mecn_status_t status;

  mecn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mecn_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[dv/tb_min_eigen_corner_nms_unit.sv]
// testbench for the min-eigenvalue corner detector with 3x3 non-maximum suppression
module tb_min_eigen_corner_nms_unit;
  import mecn_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int TARGET_ITEMS   = 1750;

  typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    logic [32:0] score;
  } feature_t;

  class corner_scoreboard;
    logic signed [34:0] line_old [DEF_MAX_WIDTH];
    logic signed [34:0] line_new [DEF_MAX_WIDTH];
    logic signed [34:0] win [6];
    int                 row_pos;
    int                 col_pos;
    int                 width_reg;
    int                 height_reg;
    int                 margin_reg;
    logic signed [32:0] thresh_reg;
    feature_t           feature_q [$];
    int                 errors;

    function new();
      foreach (line_old[i]) begin
        line_old[i] = '0;
        line_new[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = 640;
      height_reg = 480;
      margin_reg = 1;
      thresh_reg = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
      case (addr)
        REG_IMAGE_WIDTH: width_reg = int'(val[11:0]);
        REG_IMAGE_HEIGHT: height_reg = int'(val[11:0]);
        REG_THRESHOLD: thresh_reg = $signed(val[32:0]);
        REG_MARGIN: margin_reg = int'(val[9:0]);
        default: ;
      endcase
    endfunction

    function logic signed [34:0] min_eigen(logic [31:0] xx, logic [31:0] xy, logic [31:0] yy);
      logic [32:0]        d;
      logic [32:0]        c;
      logic [67:0]        rad;
      logic [33:0]        root;
      logic [33:0]        t;
      logic [32:0]        trace;
      logic signed [35:0] diff;
      d = (xx >= yy) ? {1'b0, xx - yy} : {1'b0, yy - xx};
      c = xy[31] ? (33'h1_0000_0000 - {1'b0, xy}) : {1'b0, xy};
      rad = 68'(d) * 68'(d) + ((68'(c) * 68'(c)) << 2);
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        t = root | (34'd1 << b);
        if (70'(t) * 70'(t) <= 70'(rad)) root = t;
      end
      trace = {1'b0, xx} + {1'b0, yy};
      diff = $signed({3'b000, trace}) - $signed({2'b00, root});
      return 35'(diff >>> 1);
    endfunction

    function int span(int v);
      return (v < 3) ? 3 : ((v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : v);
    endfunction

    // one accepted pixel transaction: advance the raster and queue any feature it releases
    function void note_pixel(logic [IN_DATA_W-1:0] data);
      int                 w;
      int                 h;
      int                 m;
      int                 cr;
      int                 cc;
      logic signed [34:0] cur;
      logic signed [34:0] top;
      logic signed [34:0] mid;
      logic signed [34:0] s;
      feature_t           f;
      w = span(width_reg);
      h = span(height_reg);
      m = (margin_reg == 0) ? 1 : margin_reg;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      cur = min_eigen(data[31:0], data[63:32], data[95:64]);
      top = line_old[col_pos];
      mid = line_new[col_pos];
      line_old[col_pos] = mid;
      line_new[col_pos] = cur;
      cr = row_pos - 1;
      cc = col_pos - 1;
      s = win[1];
      if (cr >= m && cr < h - m && cc >= m && cc < w - m && s >= thresh_reg &&
          s >= win[0] && s >= win[2] && s >= win[3] && s >= win[4] && s >= win[5] &&
          s >= top && s >= mid && s >= cur) begin
        f.row   = 11'(cr);
        f.col   = 11'(cc);
        f.score = s[32:0];
        feature_q = {feature_q, f};
      end
      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = top;
      win[1] = mid;
      win[2] = cur;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_feature(logic [OUT_DATA_W-1:0] data);
      feature_t exp_f;
      if (feature_q.size() == 0) begin
        $error("unexpected feature transaction %h", data);
        errors++;
        return;
      end
      exp_f = feature_q.pop_front();
      if (data[10:0] !== exp_f.row) begin
        $error("feature_row expected %0d actual %0d", exp_f.row, data[10:0]);
        errors++;
      end
      if (data[21:11] !== exp_f.col) begin
        $error("feature_col expected %0d actual %0d", exp_f.col, data[21:11]);
        errors++;
      end
      if (data[54:22] !== exp_f.score) begin
        $error("feature_score expected %0d actual %0d", $signed(exp_f.score),
               $signed(data[54:22]));
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  corner_scoreboard sb;
  bit               calm;
  int               stall_left;
  int               idle_cycles;
  int               pixels_sent;

  min_eigen_corner_nms_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function int gap_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_feature(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(logic [31:0] xx, logic [31:0] xy, logic [31:0] yy);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yy, xy, xx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel({yy, xy, xx});
    pixels_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.feature_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_frame(int w, int h, logic [32:0] thr, int m);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[REG_IMAGE_WIDTH]  = CFG_DATA_W'(w);
    vals[REG_IMAGE_HEIGHT] = CFG_DATA_W'(h);
    vals[REG_THRESHOLD]    = thr;
    vals[REG_MARGIN]       = CFG_DATA_W'(m);
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= CFG_ADDR_W'(i);
      cfg_data <= vals[i];
      sb.write_reg(CFG_ADDR_W'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // flat patches make ties, full range hits the arithmetic corners
  task automatic send_random_pixel();
    int          p;
    logic [31:0] xx;
    logic [31:0] xy;
    logic [31:0] yy;
    p = $urandom_range(0, 99);
    xx = $urandom();
    xy = $urandom();
    yy = $urandom();
    if (p < 35) begin
      xx = $urandom_range(0, 15);
      yy = $urandom_range(0, 15);
      xy = 32'($signed($urandom_range(0, 8)) - 4);
    end else if (p < 45) begin
      xx = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      yy = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      xy = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    send_pixel(xx, xy, yy);
  endtask

  task automatic run_frames(int w, int h, int frames);
    for (int f = 0; f < frames; f++)
      for (int i = 0; i < sb.span(w) * sb.span(h); i++) send_random_pixel();
  endtask

  initial begin
    logic [31:0] dir_xx [25];
    logic [31:0] dir_xy [25];
    logic [31:0] dir_yy [25];
    int          w;
    int          h;
    int          m;
    int          p;
    logic [32:0] thr;
    sb          = new();
    calm        = 1'b0;
    pixels_sent = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 5x5 frame of directed values: largest score in the middle, extremes around it
    foreach (dir_xx[i]) begin
      dir_xx[i] = $urandom_range(0, 1000);
      dir_xy[i] = $urandom_range(0, 100);
      dir_yy[i] = $urandom_range(0, 1000);
    end
    dir_xx[12] = 32'hFFFF_FFFF; dir_xy[12] = 32'h0;         dir_yy[12] = 32'hFFFF_FFFF;
    dir_xx[6]  = 32'hFFFF_FFFF; dir_xy[6]  = 32'h8000_0000; dir_yy[6]  = 32'h0;
    dir_xx[7]  = 32'h0;         dir_xy[7]  = 32'h8000_0000; dir_yy[7]  = 32'h0;
    dir_xx[8]  = 32'h0;         dir_xy[8]  = 32'h7FFF_FFFF; dir_yy[8]  = 32'hFFFF_FFFF;
    dir_xx[16] = 32'hFFFF_FFFF; dir_xy[16] = 32'hFFFF_FFFF; dir_yy[16] = 32'hFFFF_FFFE;
    dir_xx[18] = 32'h0;         dir_xy[18] = 32'h0;         dir_yy[18] = 32'h0;
    program_frame(5, 5, 33'h0, 1);
    for (int i = 0; i < 25; i++) send_pixel(dir_xx[i], dir_xy[i], dir_yy[i]);
    drain();

    // clamped sizes and zero margin, lowest threshold
    program_frame(1, 2, 33'h1_0000_0000, 0);
    run_frames(1, 2, 3);
    drain();
    // wide row
    program_frame(256, 3, 33'h1_0000_0000, 1);
    run_frames(256, 3, 1);
    drain();
    // margin too large, highest threshold
    program_frame(12, 8, 33'h0_FFFF_FFFF, 1023);
    run_frames(12, 8, 1);
    drain();

    while (pixels_sent < TARGET_ITEMS) begin
      w = $urandom_range(3, 16);
      h = $urandom_range(3, 10);
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 1;
      p = $urandom_range(0, 9);
      if (p == 0) thr = 33'h1_0000_0000;
      else if (p == 1) thr = 33'h0_FFFF_FFFF;
      else if (p < 6) thr = 33'($signed($urandom_range(0, 20)) - 10);
      else thr = {1'($urandom_range(0, 1)), 32'($urandom())};
      calm = ($urandom_range(0, 4) == 0);
      program_frame(w, h, thr, m);
      run_frames(w, h, $urandom_range(1, 2));
      drain();
    end

    if (sb.errors == 0 && sb.feature_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mecn_pkg.sv
rtl/mecn_ram.sv
rtl/mecn_ctrl.sv
rtl/mecn_dp.sv
rtl/min_eigen_corner_nms_unit.sv
dv/tb_min_eigen_corner_nms_unit.sv
